// ===== src/ncbd_pkg.sv =====
package ncbd_pkg;

    localparam int IDX_W       = 15;
    localparam int DATA_W      = 8;
    localparam int PATTERN_AW  = 13;
    localparam int NT_AW       = 11;
    localparam int NT_PAGE_AW  = 10;
    localparam int PRG_BANK_AW = 14;
    localparam int PRG_ROM_AW  = 15;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [15:0] PATTERN_END  = 16'h2000;
    localparam logic [15:0] NT_END       = 16'h3F00;
    localparam logic [15:0] NT_FOLD_BASE = 16'h3000;
    localparam logic [15:0] NT_FOLD      = 16'h1000;
    localparam logic [15:0] PRG_RAM_BASE = 16'h6000;
    localparam logic [15:0] PRG_ROM_BASE = 16'h8000;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_LOAD  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_PRG_ROM_BANKS  = 2'd0,
        CFG_PATTERN_IS_RAM = 2'd1,
        CFG_MIRROR_MODE    = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        TGT_PATTERN   = 3'd0,
        TGT_NAMETABLE = 3'd1,
        TGT_PRG_RAM   = 3'd2,
        TGT_PRG_ROM   = 3'd3,
        TGT_UNMAPPED  = 3'd4
    } target_t;

    typedef struct packed {
        logic [1:0] prg_rom_banks;
        logic       pattern_is_ram;
        logic       mirror_mode;
    } cfg_t;

    typedef struct packed {
        target_t           target;
        logic [IDX_W-1:0]  idx;
        logic              rd_en;
        logic              wr_en;
        logic [DATA_W-1:0] data;
    } op_t;

endpackage

// ===== src/ncbd_if.sv =====
interface ncbd_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [15:0] address;
    logic [7:0]  write_data;

    modport source (output valid, command, address, write_data, input ready);
    modport sink   (input valid, command, address, write_data, output ready);
endinterface

interface ncbd_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       stored;

    modport source (output valid, read_data, stored, input ready);
    modport sink   (input valid, read_data, stored, output ready);
endinterface

// ===== src/nrom_cartridge_bus_decode_top.sv =====
// Path: a result reaches rsp through the queue, the pending stage and the output register.
// Throughput: one access per cycle while rsp takes every beat; the four memories have one
// port each. A stalled result holds the pending stage, the two-entry queue then fills and
// req is held off for as long as rsp stalls.
// Reset: rst_n clears queue, pipeline valids, the unmapped byte and the configuration
// (two ROM banks, pattern ROM, horizontal mirroring); memory contents are not cleared.
module nrom_cartridge_bus_decode_top #(
    parameter int PRG_RAM_BYTES = 8192
) (
    input  logic       clk,
    input  logic       rst_n,
    ncbd_req_if.sink   req,
    ncbd_rsp_if.source rsp,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [1:0] cfg_data
);

    logic          q_full;
    logic          push;
    ncbd_pkg::op_t push_op;
    logic          pop;
    logic          head_valid;
    ncbd_pkg::op_t head_op;

    ncbd_front #(.PRG_RAM_BYTES(PRG_RAM_BYTES)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .q_full    (q_full),
        .push      (push),
        .push_op   (push_op)
    );

    ncbd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    ncbd_back #(.PRG_RAM_BYTES(PRG_RAM_BYTES)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_op    (head_op),
        .pop        (pop),
        .rsp        (rsp)
    );

endmodule

// ===== src/ncbd_ram.sv =====
module ncbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/ncbd_front.sv =====
module ncbd_front #(
    parameter int PRG_RAM_BYTES = 8192
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [1:0]      cfg_data,
    ncbd_req_if.sink        req,
    input  logic            q_full,
    output logic            push,
    output ncbd_pkg::op_t   push_op
);

    ncbd_pkg::cfg_t cfg_reg;
    ncbd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (ncbd_pkg::cfg_idx_t'(cfg_index))
                ncbd_pkg::CFG_PRG_ROM_BANKS:  cfg_next.prg_rom_banks  = cfg_data;
                ncbd_pkg::CFG_PATTERN_IS_RAM: cfg_next.pattern_is_ram = cfg_data[0];
                ncbd_pkg::CFG_MIRROR_MODE:    cfg_next.mirror_mode    = cfg_data[0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prg_rom_banks  <= 2'd2;
            cfg_reg.pattern_is_ram <= 1'b0;
            cfg_reg.mirror_mode    <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign req.ready = !q_full;
    assign push      = req.valid && !q_full;

    logic [13:0] ram_off;
    logic        rom_like;
    logic        nt_page;
    logic [15:0] nt_addr;

    always_comb
    begin
        ram_off  = {1'b0, req.address[12:0]};
        // bring the offset below the RAM size; it starts below four times that size
        for (int i = 0; i < 3; i++)
        begin
            if (ram_off >= 14'(PRG_RAM_BYTES))
            begin
                ram_off = ram_off - 14'(PRG_RAM_BYTES);
            end
        end

        nt_addr = req.address;
        if (req.address >= ncbd_pkg::NT_FOLD_BASE)
        begin
            nt_addr = req.address - ncbd_pkg::NT_FOLD;
        end
        nt_page = cfg_reg.mirror_mode ? nt_addr[10] : nt_addr[11];

        rom_like       = 1'b0;
        push_op.target = ncbd_pkg::TGT_UNMAPPED;
        push_op.idx    = '0;
        if (req.address < ncbd_pkg::PATTERN_END)
        begin
            push_op.target = ncbd_pkg::TGT_PATTERN;
            push_op.idx    = ncbd_pkg::IDX_W'(req.address[ncbd_pkg::PATTERN_AW-1:0]);
            rom_like       = !cfg_reg.pattern_is_ram;
        end
        else if (req.address < ncbd_pkg::NT_END)
        begin
            push_op.target = ncbd_pkg::TGT_NAMETABLE;
            push_op.idx    = ncbd_pkg::IDX_W'({nt_page,
                                               nt_addr[ncbd_pkg::NT_PAGE_AW-1:0]});
        end
        else if (req.address >= ncbd_pkg::PRG_RAM_BASE
                 && req.address < ncbd_pkg::PRG_ROM_BASE)
        begin
            push_op.target = ncbd_pkg::TGT_PRG_RAM;
            push_op.idx    = ncbd_pkg::IDX_W'(ram_off);
        end
        else if (req.address >= ncbd_pkg::PRG_ROM_BASE)
        begin
            rom_like = 1'b1;
            if (cfg_reg.prg_rom_banks == 2'd1)
            begin
                push_op.target = ncbd_pkg::TGT_PRG_ROM;
                push_op.idx    = ncbd_pkg::IDX_W'(req.address[ncbd_pkg::PRG_BANK_AW-1:0]);
            end
            else if (cfg_reg.prg_rom_banks != 2'd0)
            begin
                // three banks saturate to two
                push_op.target = ncbd_pkg::TGT_PRG_ROM;
                push_op.idx    = req.address[ncbd_pkg::PRG_ROM_AW-1:0];
            end
        end

        push_op.rd_en = 1'b0;
        push_op.wr_en = 1'b0;
        push_op.data  = req.write_data;
        case (ncbd_pkg::cmd_t'(req.command))
            ncbd_pkg::CMD_READ:  push_op.rd_en = 1'b1;
            ncbd_pkg::CMD_WRITE: push_op.wr_en = !rom_like;
            ncbd_pkg::CMD_LOAD:  push_op.wr_en = 1'b1;
            default:
            begin
                push_op.rd_en = 1'b0;
                push_op.wr_en = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/ncbd_queue.sv =====
module ncbd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ncbd_pkg::op_t  push_op,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output ncbd_pkg::op_t  head_op
);

    localparam int PTR_W = (ncbd_pkg::QUEUE_DEPTH > 1) ? $clog2(ncbd_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(ncbd_pkg::QUEUE_DEPTH + 1);

    ncbd_pkg::op_t    slot_reg [ncbd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(ncbd_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(ncbd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(ncbd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ===== src/ncbd_back.sv =====
module ncbd_back #(
    parameter int PRG_RAM_BYTES = 8192
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  ncbd_pkg::op_t  head_op,
    output logic           pop,
    ncbd_rsp_if.source     rsp
);

    localparam int PRG_RAM_AW = $clog2(PRG_RAM_BYTES);

    logic                            pend_valid_reg, pend_valid_next;
    ncbd_pkg::target_t               pend_target_reg;
    logic                            pend_rd_reg;
    logic                            pend_wr_reg;
    logic [ncbd_pkg::DATA_W-1:0]     pend_unmapped_reg;
    logic [ncbd_pkg::DATA_W-1:0]     unmapped_reg, unmapped_next;
    logic                            out_valid_reg, out_valid_next;
    logic [ncbd_pkg::DATA_W-1:0]     read_data_reg;
    logic                            stored_reg;

    logic                            pend_move;
    logic                            en_pat, en_nt, en_ram, en_rom;
    logic [ncbd_pkg::DATA_W-1:0]     rd_pat, rd_nt, rd_ram, rd_rom;
    logic [ncbd_pkg::DATA_W-1:0]     pend_data;

    assign pend_move = pend_valid_reg && (!out_valid_reg || rsp.ready);
    // issue only when the pending slot frees, so the RAM read registers hold while stalled
    assign pop       = head_valid && (!pend_valid_reg || pend_move);

    assign en_pat = pop && (head_op.target == ncbd_pkg::TGT_PATTERN);
    assign en_nt  = pop && (head_op.target == ncbd_pkg::TGT_NAMETABLE);
    assign en_ram = pop && (head_op.target == ncbd_pkg::TGT_PRG_RAM);
    assign en_rom = pop && (head_op.target == ncbd_pkg::TGT_PRG_ROM);

    ncbd_ram #(.WIDTH(ncbd_pkg::DATA_W), .DEPTH(1 << ncbd_pkg::PATTERN_AW)) u_pattern (
        .clk   (clk),
        .en    (en_pat),
        .we    (head_op.wr_en),
        .addr  (head_op.idx[ncbd_pkg::PATTERN_AW-1:0]),
        .wdata (head_op.data),
        .rdata (rd_pat)
    );

    ncbd_ram #(.WIDTH(ncbd_pkg::DATA_W), .DEPTH(1 << ncbd_pkg::NT_AW)) u_nametable (
        .clk   (clk),
        .en    (en_nt),
        .we    (head_op.wr_en),
        .addr  (head_op.idx[ncbd_pkg::NT_AW-1:0]),
        .wdata (head_op.data),
        .rdata (rd_nt)
    );

    ncbd_ram #(.WIDTH(ncbd_pkg::DATA_W), .DEPTH(PRG_RAM_BYTES)) u_prg_ram (
        .clk   (clk),
        .en    (en_ram),
        .we    (head_op.wr_en),
        .addr  (head_op.idx[PRG_RAM_AW-1:0]),
        .wdata (head_op.data),
        .rdata (rd_ram)
    );

    ncbd_ram #(.WIDTH(ncbd_pkg::DATA_W), .DEPTH(1 << ncbd_pkg::PRG_ROM_AW)) u_prg_rom (
        .clk   (clk),
        .en    (en_rom),
        .we    (head_op.wr_en),
        .addr  (head_op.idx[ncbd_pkg::PRG_ROM_AW-1:0]),
        .wdata (head_op.data),
        .rdata (rd_rom)
    );

    always_comb
    begin
        unmapped_next = unmapped_reg;
        if (pop && head_op.target == ncbd_pkg::TGT_UNMAPPED && head_op.wr_en)
        begin
            unmapped_next = head_op.data;
        end

        pend_valid_next = pend_valid_reg;
        if (pop)
        begin
            pend_valid_next = 1'b1;
        end
        else if (pend_move)
        begin
            pend_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (pend_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (pend_target_reg)
            ncbd_pkg::TGT_PATTERN:   pend_data = rd_pat;
            ncbd_pkg::TGT_NAMETABLE: pend_data = rd_nt;
            ncbd_pkg::TGT_PRG_RAM:   pend_data = rd_ram;
            ncbd_pkg::TGT_PRG_ROM:   pend_data = rd_rom;
            default:                 pend_data = pend_unmapped_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            unmapped_reg   <= '0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            unmapped_reg   <= unmapped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            pend_target_reg   <= head_op.target;
            pend_rd_reg       <= head_op.rd_en;
            pend_wr_reg       <= head_op.wr_en;
            pend_unmapped_reg <= unmapped_reg;
        end
        if (pend_move)
        begin
            read_data_reg <= pend_rd_reg ? pend_data : '0;
            stored_reg    <= pend_wr_reg;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = read_data_reg;
    assign rsp.stored    = stored_reg;

endmodule

// ===== src/ncbd_checker.sv =====
module ncbd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [7:0] rsp_read_data,
    input logic       rsp_stored
);

    logic [2:0] outstanding_reg, outstanding_next;
    logic       req_beat, rsp_beat;

    assign req_beat = req_valid && req_ready;
    assign rsp_beat = rsp_valid && rsp_ready;

    always_comb
    begin
        outstanding_next = outstanding_reg;
        if (req_beat && !rsp_beat)
        begin
            outstanding_next = outstanding_reg + 1'b1;
        end
        else if (rsp_beat && !req_beat)
        begin
            outstanding_next = outstanding_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data) && $stable(rsp_stored))
        else $error("result beat dropped or changed while stalled");

    a_stored_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stored |-> rsp_read_data == 8'd0)
        else $error("store result carries read data");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> outstanding_reg != 3'd0)
        else $error("result without an outstanding access");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= 3'd4)
        else $error("more accesses in flight than queue and pipeline hold");

endmodule

bind nrom_cartridge_bus_decode_top ncbd_checker u_ncbd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_read_data (rsp.read_data),
    .rsp_stored    (rsp.stored)
);
